// ===== design/kvt_pkg.sv =====
package kvt_pkg;

    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 3;
    localparam int WORD_BITS   = 32;
    localparam int COUNT_BITS  = 5;

    localparam logic [ACTION_BITS-1:0] ACT_SET    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_GET    = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STATUS_BITS-1:0] STAT_UPDATED  = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_INSERTED = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_FOUND    = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_MISSING  = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_FULL     = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_RESPOND
    } state_t;

endpackage

// ===== design/kvt_store.sv =====
module kvt_store #(
    parameter int DEPTH = 16,
    parameter int KW    = 32,
    parameter int VW    = 32,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [KW-1:0] wr_key,
    input  logic [VW-1:0] wr_value,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [KW-1:0] rd_key,
    output logic [VW-1:0] rd_value
);

    logic [KW-1:0] key_mem   [DEPTH];
    logic [VW-1:0] value_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key   <= key_mem[rd_addr];
            rd_value <= value_mem[rd_addr];
        end
    end

endmodule

// ===== design/packed_key_value_table.sv =====
// Key-value table of up to CAPACITY pairs kept packed in insertion order in a
// single-port-read memory. Each transaction sets, gets or removes one key and
// returns one result. The key search reads one stored entry per cycle. A
// remove that hits shifts every later entry down one place through the same
// read and write ports. The input is not ready while a transaction is in
// progress; a finished result waits in the output register while the next
// one is searched, and that one waits to respond until the first is taken.
module packed_key_value_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kvt_pkg::ACTION_BITS-1:0]   s_action,
    input  logic [kvt_pkg::WORD_BITS-1:0]     s_key,
    input  logic [kvt_pkg::WORD_BITS-1:0]     s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [kvt_pkg::STATUS_BITS-1:0]   m_status,
    output logic [kvt_pkg::WORD_BITS-1:0]     m_read_value,
    output logic [kvt_pkg::COUNT_BITS-1:0]    m_entry_count
);

    localparam int KW = (KEY_BITS < kvt_pkg::WORD_BITS) ? KEY_BITS : kvt_pkg::WORD_BITS;
    localparam int VW = (VALUE_BITS < kvt_pkg::WORD_BITS) ? VALUE_BITS : kvt_pkg::WORD_BITS;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    kvt_pkg::state_t                 state_reg, state_next;
    logic [kvt_pkg::ACTION_BITS-1:0] act_reg, act_next;
    logic [KW-1:0]                   key_reg, key_next;
    logic [VW-1:0]                   value_reg, value_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   scan_reg, scan_next;
    logic                            pend_reg, pend_next;
    logic [kvt_pkg::STATUS_BITS-1:0] res_status_reg, res_status_next;
    logic [VW-1:0]                   res_value_reg, res_value_next;
    logic                            m_valid_reg, m_valid_next;
    logic [kvt_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [kvt_pkg::WORD_BITS-1:0]   m_read_value_reg, m_read_value_next;
    logic [kvt_pkg::COUNT_BITS-1:0]  m_entry_count_reg, m_entry_count_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_key;
    logic [VW-1:0] wr_value;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_key;
    logic [VW-1:0] rd_value;
    logic          hit;
    logic [CW-1:0] prev_pos;

    kvt_store #(
        .DEPTH (CAPACITY),
        .KW    (KW),
        .VW    (VW),
        .AW    (AW)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    assign s_ready       = (state_reg == kvt_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_entry_count = m_entry_count_reg;

    assign hit      = pend_reg && (rd_key == key_reg);
    assign prev_pos = scan_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kvt_pkg::ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg           <= act_next;
        key_reg           <= key_next;
        value_reg         <= value_next;
        scan_reg          <= scan_next;
        res_status_reg    <= res_status_next;
        res_value_reg     <= res_value_next;
        m_status_reg      <= m_status_next;
        m_read_value_reg  <= m_read_value_next;
        m_entry_count_reg <= m_entry_count_next;
    end

    always_comb begin
        state_next         = state_reg;
        act_next           = act_reg;
        key_next           = key_reg;
        value_next         = value_reg;
        count_next         = count_reg;
        scan_next          = scan_reg;
        pend_next          = 1'b0;
        res_status_next    = res_status_reg;
        res_value_next     = res_value_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_read_value_next  = m_read_value_reg;
        m_entry_count_next = m_entry_count_reg;
        wr_en              = 1'b0;
        wr_addr            = prev_pos[AW-1:0];
        wr_key             = key_reg;
        wr_value           = value_reg;
        rd_en              = 1'b0;
        rd_addr            = scan_reg[AW-1:0];

        unique case (state_reg)
            kvt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    act_next        = s_action;
                    key_next        = s_key[KW-1:0];
                    value_next      = s_value[VW-1:0];
                    scan_next       = '0;
                    res_status_next = kvt_pkg::STAT_MISSING;
                    res_value_next  = '0;
                    state_next      = kvt_pkg::ST_SEARCH;
                end
            end
            kvt_pkg::ST_SEARCH: begin
                if (hit) begin
                    unique case (act_reg)
                        kvt_pkg::ACT_SET: begin
                            wr_en           = 1'b1;
                            res_status_next = kvt_pkg::STAT_UPDATED;
                            state_next      = kvt_pkg::ST_RESPOND;
                        end
                        kvt_pkg::ACT_GET: begin
                            res_value_next  = rd_value;
                            res_status_next = kvt_pkg::STAT_FOUND;
                            state_next      = kvt_pkg::ST_RESPOND;
                        end
                        kvt_pkg::ACT_REMOVE: begin
                            res_status_next = kvt_pkg::STAT_FOUND;
                            state_next      = kvt_pkg::ST_SHIFT_RD;
                        end
                        default: begin
                            state_next = kvt_pkg::ST_RESPOND;
                        end
                    endcase
                end else if (scan_reg >= count_reg) begin
                    if (act_reg == kvt_pkg::ACT_SET) begin
                        if (count_reg < CAP) begin
                            wr_en           = 1'b1;
                            wr_addr         = count_reg[AW-1:0];
                            count_next      = count_reg + 1'b1;
                            res_status_next = kvt_pkg::STAT_INSERTED;
                        end else begin
                            res_status_next = kvt_pkg::STAT_FULL;
                        end
                    end
                    state_next = kvt_pkg::ST_RESPOND;
                end else begin
                    rd_en     = 1'b1;
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            kvt_pkg::ST_SHIFT_RD: begin
                if (scan_reg < count_reg) begin
                    rd_en      = 1'b1;
                    state_next = kvt_pkg::ST_SHIFT_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = kvt_pkg::ST_RESPOND;
                end
            end
            kvt_pkg::ST_SHIFT_WR: begin
                wr_en      = 1'b1;
                wr_key     = rd_key;
                wr_value   = rd_value;
                scan_next  = scan_reg + 1'b1;
                state_next = kvt_pkg::ST_SHIFT_RD;
            end
            kvt_pkg::ST_RESPOND: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_status_next      = res_status_reg;
                    m_read_value_next  = kvt_pkg::WORD_BITS'(res_value_reg);
                    m_entry_count_next = kvt_pkg::COUNT_BITS'(count_reg);
                    state_next         = kvt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = kvt_pkg::ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP)
        else $error("entry count exceeds capacity");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in progress");

    a_full_only_at_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kvt_pkg::ST_RESPOND && res_status_reg == kvt_pkg::STAT_FULL
        |-> count_reg == CAP)
        else $error("table full reported below capacity");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_read_value)
        && $stable(m_entry_count))
        else $error("pending result changed before it was taken");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> {1'b0, wr_addr} < {1'b0, AW'(CAPACITY - 1)} + 1'b1)
        else $error("write beyond table capacity");

endmodule
